// ----- sv/ubx_df_pkg.sv -----
// Shared types and constants for the UBX frame deframer.
// Used by ubx_df_front, ubx_df_queue, ubx_df_back and ubx_frame_deframer.
package ubx_df_pkg;

  // Largest payload the hardware accepts, whatever length_limit says.
  localparam logic [9:0] MAX_PAYLOAD = 10'd1016;

  // Command queue between the front and back parts.
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Configuration register indexes.
  localparam logic [1:0] CFG_SYNC_FIRST   = 2'd0;
  localparam logic [1:0] CFG_SYNC_SECOND  = 2'd1;
  localparam logic [1:0] CFG_LENGTH_LIMIT = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [7:0] SYNC_FIRST_RST   = 8'd181;
  localparam logic [7:0] SYNC_SECOND_RST  = 8'd98;
  localparam logic [9:0] LENGTH_LIMIT_RST = 10'd1016;

  // Result kinds.
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_ACCEPT  = 2'd1;
  localparam logic [1:0] KIND_REJECT  = 2'd2;

  // Error codes.
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_SYNC   = 2'd1;
  localparam logic [1:0] ERR_LENGTH = 2'd2;
  localparam logic [1:0] ERR_CKSUM  = 2'd3;

  // Parser phase.
  typedef enum logic [3:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_CLASS,
    PH_ID,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PAYLOAD,
    PH_CK_A,
    PH_CK_B
  } phase_e;

  // Operation the back part carries out for one byte.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_SUM_CLR,
    OP_HDR,
    OP_PAYLOAD,
    OP_CK_A,
    OP_CK_B,
    OP_SYNC_ERR,
    OP_LEN_ERR
  } op_e;

  // One queued command with the frame context it needs.
  typedef struct packed {
    op_e         op;
    logic [7:0]  data;
    logic [9:0]  index;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] msg_length;
  } cmd_t;

endpackage

// ----- sv/ubx_df_front.sv -----
// Front part: holds the configuration, tracks the frame phase and classifies
// each incoming byte into a command. Depends on ubx_df_pkg.
module ubx_df_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [9:0]        cfg_data_i,
  input  logic              acc_i,
  input  logic [7:0]        byte_i,
  output ubx_df_pkg::cmd_t  cmd_o
);

  logic [7:0]  sync_first_q, sync_second_q;
  logic [9:0]  length_limit_q;
  ubx_df_pkg::phase_e phase_q, phase_d;
  logic [7:0]  cls_q, cls_d;
  logic [7:0]  id_q, id_d;
  logic [15:0] len_q, len_d;
  logic [9:0]  seen_q, seen_d;
  logic [9:0]  limit;
  logic [15:0] len_full;
  logic [10:0] seen_next;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q   <= ubx_df_pkg::SYNC_FIRST_RST;
      sync_second_q  <= ubx_df_pkg::SYNC_SECOND_RST;
      length_limit_q <= ubx_df_pkg::LENGTH_LIMIT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ubx_df_pkg::CFG_SYNC_FIRST:   sync_first_q   <= cfg_data_i[7:0];
        ubx_df_pkg::CFG_SYNC_SECOND:  sync_second_q  <= cfg_data_i[7:0];
        ubx_df_pkg::CFG_LENGTH_LIMIT: length_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Phase and header context registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ubx_df_pkg::PH_SYNC1;
      cls_q   <= '0;
      id_q    <= '0;
      len_q   <= '0;
      seen_q  <= '0;
    end else if (acc_i) begin
      phase_q <= phase_d;
      cls_q   <= cls_d;
      id_q    <= id_d;
      len_q   <= len_d;
      seen_q  <= seen_d;
    end
  end

  assign limit     = (length_limit_q > ubx_df_pkg::MAX_PAYLOAD) ?
                     ubx_df_pkg::MAX_PAYLOAD : length_limit_q;
  assign len_full  = {byte_i, len_q[7:0]};
  assign seen_next = {1'b0, seen_q} + 11'd1;

  // Next phase and command classification
  always_comb begin
    phase_d   = phase_q;
    cls_d     = cls_q;
    id_d      = id_q;
    len_d     = len_q;
    seen_d    = seen_q;
    cmd_o.op  = ubx_df_pkg::OP_NOP;
    unique case (phase_q)
      ubx_df_pkg::PH_SYNC1: begin
        if (byte_i != sync_first_q) begin
          cls_d    = '0;
          id_d     = '0;
          len_d    = '0;
          cmd_o.op = ubx_df_pkg::OP_SYNC_ERR;
        end else begin
          phase_d = ubx_df_pkg::PH_SYNC2;
        end
      end
      ubx_df_pkg::PH_SYNC2: begin
        if (byte_i != sync_second_q) begin
          cls_d    = '0;
          id_d     = '0;
          len_d    = '0;
          cmd_o.op = ubx_df_pkg::OP_SYNC_ERR;
          phase_d  = ubx_df_pkg::PH_SYNC1;
        end else begin
          cmd_o.op = ubx_df_pkg::OP_SUM_CLR;
          phase_d  = ubx_df_pkg::PH_CLASS;
        end
      end
      ubx_df_pkg::PH_CLASS: begin
        cls_d    = byte_i;
        id_d     = '0;
        len_d    = '0;
        cmd_o.op = ubx_df_pkg::OP_HDR;
        phase_d  = ubx_df_pkg::PH_ID;
      end
      ubx_df_pkg::PH_ID: begin
        id_d     = byte_i;
        cmd_o.op = ubx_df_pkg::OP_HDR;
        phase_d  = ubx_df_pkg::PH_LEN_LO;
      end
      ubx_df_pkg::PH_LEN_LO: begin
        len_d    = {8'd0, byte_i};
        cmd_o.op = ubx_df_pkg::OP_HDR;
        phase_d  = ubx_df_pkg::PH_LEN_HI;
      end
      ubx_df_pkg::PH_LEN_HI: begin
        len_d  = len_full;
        seen_d = '0;
        // Header bytes are summed even when the length is refused; the sum
        // is cleared again at the next sync anyway.
        if (len_full > {6'd0, limit}) begin
          cmd_o.op = ubx_df_pkg::OP_LEN_ERR;
          phase_d  = ubx_df_pkg::PH_SYNC1;
        end else begin
          cmd_o.op = ubx_df_pkg::OP_HDR;
          phase_d  = (len_full == 16'd0) ? ubx_df_pkg::PH_CK_A : ubx_df_pkg::PH_PAYLOAD;
        end
      end
      ubx_df_pkg::PH_PAYLOAD: begin
        cmd_o.op = ubx_df_pkg::OP_PAYLOAD;
        seen_d   = seen_next[9:0];
        if ({5'd0, seen_next} >= len_q) begin
          phase_d = ubx_df_pkg::PH_CK_A;
        end
      end
      ubx_df_pkg::PH_CK_A: begin
        cmd_o.op = ubx_df_pkg::OP_CK_A;
        phase_d  = ubx_df_pkg::PH_CK_B;
      end
      ubx_df_pkg::PH_CK_B: begin
        cmd_o.op = ubx_df_pkg::OP_CK_B;
        phase_d  = ubx_df_pkg::PH_SYNC1;
      end
      default: begin
        phase_d = ubx_df_pkg::PH_SYNC1;
      end
    endcase
    cmd_o.data       = byte_i;
    cmd_o.index      = seen_q;
    cmd_o.msg_class  = cls_d;
    cmd_o.msg_id     = id_d;
    cmd_o.msg_length = len_d;
  end

endmodule

// ----- sv/ubx_df_queue.sv -----
// Short command queue that decouples the front and back parts.
// Depends on ubx_df_pkg.
module ubx_df_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ubx_df_pkg::cmd_t  push_cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              nonempty_o,
  output ubx_df_pkg::cmd_t  head_o
);

  ubx_df_pkg::cmd_t mem_q [ubx_df_pkg::Q_DEPTH];
  logic [ubx_df_pkg::Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [ubx_df_pkg::Q_CNT_W-1:0] cnt_q;

  assign full_o     = (cnt_q == ubx_df_pkg::Q_CNT_W'(ubx_df_pkg::Q_DEPTH));
  assign nonempty_o = (cnt_q != '0);
  assign head_o     = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- sv/ubx_df_back.sv -----
// Back part: runs the Fletcher sums, checks the trailer, counts errors and
// holds the result in an output register. Depends on ubx_df_pkg.
module ubx_df_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              nonempty_i,
  input  ubx_df_pkg::cmd_t  cmd_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        kind_o,
  output logic [7:0]        data_byte_o,
  output logic [9:0]        payload_index_o,
  output logic [7:0]        msg_class_o,
  output logic [7:0]        msg_id_o,
  output logic [15:0]       msg_length_o,
  output logic [1:0]        error_code_o,
  output logic [15:0]       error_count_o,
  output logic              frame_last_o
);

  logic [7:0]  sum_a_q, sum_a_d, sum_b_q, sum_b_d, ck_a_q;
  logic [15:0] err_cnt_q, err_cnt_d, err_cnt_inc;
  logic        out_valid_q;
  logic        needs_out, out_free, load;
  logic [7:0]  add_a;
  logic        is_err;
  logic [1:0]  kind_d, code_d;

  assign add_a       = sum_a_q + cmd_i.data;
  assign err_cnt_inc = (err_cnt_q != 16'hFFFF) ? err_cnt_q + 16'd1 : err_cnt_q;

  assign needs_out = (cmd_i.op == ubx_df_pkg::OP_PAYLOAD) ||
                     (cmd_i.op == ubx_df_pkg::OP_CK_B) ||
                     (cmd_i.op == ubx_df_pkg::OP_SYNC_ERR) ||
                     (cmd_i.op == ubx_df_pkg::OP_LEN_ERR);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign pop_o     = nonempty_i && (!needs_out || out_free);
  assign load      = pop_o && needs_out;

  // Command execution
  always_comb begin
    sum_a_d   = sum_a_q;
    sum_b_d   = sum_b_q;
    err_cnt_d = err_cnt_q;
    is_err    = 1'b0;
    kind_d    = ubx_df_pkg::KIND_PAYLOAD;
    code_d    = ubx_df_pkg::ERR_NONE;
    unique case (cmd_i.op)
      ubx_df_pkg::OP_SUM_CLR: begin
        sum_a_d = '0;
        sum_b_d = '0;
      end
      ubx_df_pkg::OP_HDR, ubx_df_pkg::OP_PAYLOAD: begin
        sum_a_d = add_a;
        sum_b_d = sum_b_q + add_a;
      end
      ubx_df_pkg::OP_LEN_ERR: begin
        sum_a_d = add_a;
        sum_b_d = sum_b_q + add_a;
        is_err  = 1'b1;
        code_d  = ubx_df_pkg::ERR_LENGTH;
      end
      ubx_df_pkg::OP_SYNC_ERR: begin
        is_err = 1'b1;
        code_d = ubx_df_pkg::ERR_SYNC;
      end
      ubx_df_pkg::OP_CK_B: begin
        if (ck_a_q != sum_a_q || cmd_i.data != sum_b_q) begin
          is_err = 1'b1;
          code_d = ubx_df_pkg::ERR_CKSUM;
        end else begin
          kind_d = ubx_df_pkg::KIND_ACCEPT;
        end
      end
      default: ;
    endcase
    if (is_err) begin
      kind_d    = ubx_df_pkg::KIND_REJECT;
      err_cnt_d = err_cnt_inc;
    end
  end

  // Running sums, check byte and error counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_a_q   <= '0;
      sum_b_q   <= '0;
      ck_a_q    <= '0;
      err_cnt_q <= '0;
    end else if (pop_o) begin
      sum_a_q   <= sum_a_d;
      sum_b_q   <= sum_b_d;
      err_cnt_q <= err_cnt_d;
      if (cmd_i.op == ubx_df_pkg::OP_CK_A) begin
        ck_a_q <= cmd_i.data;
      end
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= load;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_o          <= kind_d;
      data_byte_o     <= (cmd_i.op == ubx_df_pkg::OP_PAYLOAD) ? cmd_i.data : 8'd0;
      payload_index_o <= (cmd_i.op == ubx_df_pkg::OP_PAYLOAD) ? cmd_i.index : 10'd0;
      msg_class_o     <= cmd_i.msg_class;
      msg_id_o        <= cmd_i.msg_id;
      msg_length_o    <= cmd_i.msg_length;
      error_code_o    <= code_d;
      error_count_o   <= err_cnt_d;
      frame_last_o    <= (cmd_i.op != ubx_df_pkg::OP_PAYLOAD);
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- sv/ubx_frame_deframer.sv -----
// UBX frame deframer: top level joining front, command queue and back part.
// Throughput one byte per cycle while the command queue is not full; a byte's
// result passes through the command queue and then the output register, and
// can wait in the queue while the output stalls. The input stalls only when
// the 4-entry command queue is full. Reset (rst_ni low, asynchronous) restores
// the default sync bytes and limit, clears counters and hunts sync.
module ubx_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [9:0]  payload_index_o,
  output logic [7:0]  msg_class_o,
  output logic [7:0]  msg_id_o,
  output logic [15:0] msg_length_o,
  output logic [1:0]  error_code_o,
  output logic [15:0] error_count_o,
  output logic        frame_last_o
);

  ubx_df_pkg::cmd_t front_cmd, head_cmd;
  logic q_full, q_nonempty, q_pop, in_acc;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;
  assign in_acc      = in_valid_i && !q_full;

  ubx_df_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .acc_i       (in_acc),
    .byte_i      (in_byte_i),
    .cmd_o       (front_cmd)
  );

  ubx_df_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_acc),
    .push_cmd_i (front_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .nonempty_o (q_nonempty),
    .head_o     (head_cmd)
  );

  ubx_df_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .nonempty_i      (q_nonempty),
    .cmd_i           (head_cmd),
    .pop_o           (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .data_byte_o     (data_byte_o),
    .payload_index_o (payload_index_o),
    .msg_class_o     (msg_class_o),
    .msg_id_o        (msg_id_o),
    .msg_length_o    (msg_length_o),
    .error_code_o    (error_code_o),
    .error_count_o   (error_count_o),
    .frame_last_o    (frame_last_o)
  );

  // Payload results never close a frame and carry no error
  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == ubx_df_pkg::KIND_PAYLOAD |->
      !frame_last_o && error_code_o == ubx_df_pkg::ERR_NONE)
    else $error("payload result flagged as frame end or error");

  // Rejects always carry an error code and end the frame
  a_reject_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == ubx_df_pkg::KIND_REJECT |->
      error_code_o != ubx_df_pkg::ERR_NONE && frame_last_o && error_count_o != 16'd0)
    else $error("reject result without error code");

  // Accepted frames carry no error
  a_accept_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == ubx_df_pkg::KIND_ACCEPT |->
      error_code_o == ubx_df_pkg::ERR_NONE && frame_last_o)
    else $error("accept result with error code");

  // Error count never goes backward across taken results
  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i ##1 out_valid_o |-> error_count_o >= $past(error_count_o))
    else $error("error count decreased");

endmodule
